>>> rtl/core/pixel_normalize_layout_transpose_core_defines.svh
// assertion macros for the pixel normalize core
`ifndef PIXEL_NORMALIZE_LAYOUT_TRANSPOSE_CORE_DEFINES_SVH
`define PIXEL_NORMALIZE_LAYOUT_TRANSPOSE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PNLT_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PNLT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PNLT_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define PNLT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/pnlt_pkg.sv
`timescale 1ns / 1ps

package pnlt_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int CHANNELS     = 3;
  localparam int DIM_CFG_W    = 11;
  localparam int COEF_W       = 24;
  localparam int BYTE_W       = 8;
  localparam int ADDR_W       = 22;
  localparam int VALUE_W      = 32;
  localparam int PLANE_W      = 2;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_HEIGHT  = 3'd0,
    CFG_IMAGE_WIDTH   = 3'd1,
    CFG_PLANAR_LAYOUT = 3'd2,
    CFG_SWAP_RED_BLUE = 3'd3,
    CFG_GAIN          = 3'd4,
    CFG_BIAS          = 3'd5
  } cfg_reg_t;

  typedef logic [PLANE_W-1:0] plane_t;

  localparam plane_t PLANE_FIRST  = 2'd0;
  localparam plane_t PLANE_MIDDLE = 2'd1;
  localparam plane_t PLANE_LAST   = 2'd2;

  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 11'd1024;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 11'd1024;
  localparam logic                 PLANAR_RST = 1'b1;
  localparam logic                 SWAP_RST   = 1'b0;
  localparam logic [COEF_W-1:0]    GAIN_RST   = 24'd65536;
  localparam logic [COEF_W-1:0]    BIAS_RST   = 24'd0;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

endpackage

>>> rtl/core/pixel_normalize_layout_transpose_core.sv
`timescale 1ns / 1ps
// Pixel normalize and layout transpose core.
// Input channel: one beat carries one pixel as three stored bytes
// (in_byte_zero/one/two), in raster order. Result channel: three beats per
// pixel, channel 0 first, each with the destination element index, the
// scaled Q16.16 value (byte * gain + bias, saturated), the channel number
// and the pixel/image end flags. Both channels use valid and stall.
// Configuration: cfg_wr_en, cfg_index, cfg_wdata; write only while idle.
// The pixel beat is taken into the pixel register, and its first result then
// moves into the output register.
// The single result channel moves one element per cycle while out_stall is
// low, and so sets the pixel rate; the next pixel is taken in the same cycle
// as the third result of the current one moves into the output register.
// Reset (synchronous, rst_n low) clears the row and column counters, both
// pipeline valids and loads the default configuration.
// A stall on the result side holds the output register; the pixel register
// then holds too and in_stall rises until the pixel register can empty.
`include "pixel_normalize_layout_transpose_core_defines.svh"

module pixel_normalize_layout_transpose_core #(
  parameter int MAX_DIM = pnlt_pkg::MAX_DIM
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [pnlt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pnlt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [pnlt_pkg::BYTE_W-1:0]          in_byte_zero,
  input  logic [pnlt_pkg::BYTE_W-1:0]          in_byte_one,
  input  logic [pnlt_pkg::BYTE_W-1:0]          in_byte_two,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pnlt_pkg::ADDR_W-1:0]          out_dest_address,
  output logic [pnlt_pkg::VALUE_W-1:0]         out_scaled_value,
  output logic [pnlt_pkg::PLANE_W-1:0]         out_plane_index,
  output logic                                 out_pixel_done,
  output logic                                 out_image_done
);

  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int PW = CW + DW;
  localparam int AW = 2 * DW + 2;

  // configuration registers
  logic [pnlt_pkg::DIM_CFG_W-1:0] height_r, width_r;
  logic                           planar_r, swap_r;
  logic [pnlt_pkg::COEF_W-1:0]    gain_r, bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= pnlt_pkg::HEIGHT_RST;
      width_r  <= pnlt_pkg::WIDTH_RST;
      planar_r <= pnlt_pkg::PLANAR_RST;
      swap_r   <= pnlt_pkg::SWAP_RST;
      gain_r   <= pnlt_pkg::GAIN_RST;
      bias_r   <= pnlt_pkg::BIAS_RST;
    end else if (cfg_wr_en) begin
      case (pnlt_pkg::cfg_reg_t'(cfg_index))
        pnlt_pkg::CFG_IMAGE_HEIGHT:  height_r <= cfg_wdata[pnlt_pkg::DIM_CFG_W-1:0];
        pnlt_pkg::CFG_IMAGE_WIDTH:   width_r  <= cfg_wdata[pnlt_pkg::DIM_CFG_W-1:0];
        pnlt_pkg::CFG_PLANAR_LAYOUT: planar_r <= cfg_wdata[0];
        pnlt_pkg::CFG_SWAP_RED_BLUE: swap_r   <= cfg_wdata[0];
        pnlt_pkg::CFG_GAIN:          gain_r   <= cfg_wdata;
        pnlt_pkg::CFG_BIAS:          bias_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped dimensions
  logic [DW-1:0] eff_h, eff_w;

  always_comb begin
    if (height_r == '0) begin
      eff_h = DW'(1);
    end else if (32'(height_r) > 32'(MAX_DIM)) begin
      eff_h = DW'(MAX_DIM);
    end else begin
      eff_h = DW'(height_r);
    end
    if (width_r == '0) begin
      eff_w = DW'(1);
    end else if (32'(width_r) > 32'(MAX_DIM)) begin
      eff_w = DW'(MAX_DIM);
    end else begin
      eff_w = DW'(width_r);
    end
  end

  // plane size, used only once a pixel is in flight
  logic [2*DW-1:0] plane_size_r;

  always_ff @(posedge clk) begin
    plane_size_r <= (2*DW)'(eff_h) * (2*DW)'(eff_w);
  end

  // handshake
  logic            out_valid_r;
  logic            px_valid_r;
  pnlt_pkg::plane_t ch_r;
  logic            advance;
  logic            in_take;
  logic            px_last_beat;

  assign advance      = !out_valid_r || !out_stall;
  assign px_last_beat = advance && (ch_r == pnlt_pkg::PLANE_LAST);
  assign in_stall     = px_valid_r && !px_last_beat;
  assign in_take      = in_valid && !in_stall;

  // position counters
  logic [CW-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [DW:0]   col_inc, row_inc;
  logic          last_col, last_row;

  assign col_inc  = (DW+1)'(col_r) + (DW+1)'(1);
  assign row_inc  = (DW+1)'(row_r) + (DW+1)'(1);
  assign last_col = col_inc >= (DW+1)'(eff_w);
  assign last_row = row_inc >= (DW+1)'(eff_h);

  always_comb begin
    row_nxt = row_r;
    col_nxt = CW'(col_inc);
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : CW'(row_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_take) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // pixel register
  logic [pnlt_pkg::BYTE_W-1:0] b0_r, b1_r, b2_r;
  logic [PW-1:0]               pix_r;
  logic                        img_last_r;

  always_ff @(posedge clk) begin
    if (in_take) begin
      b0_r       <= in_byte_zero;
      b1_r       <= in_byte_one;
      b2_r       <= in_byte_two;
      pix_r      <= PW'(row_r) * PW'(eff_w) + PW'(col_r);
      img_last_r <= last_col && last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_valid_r <= 1'b0;
      ch_r       <= pnlt_pkg::PLANE_FIRST;
    end else begin
      if (in_take) begin
        px_valid_r <= 1'b1;
      end else if (px_valid_r && px_last_beat) begin
        px_valid_r <= 1'b0;
      end
      if (px_valid_r && advance) begin
        ch_r <= (ch_r == pnlt_pkg::PLANE_LAST) ? pnlt_pkg::PLANE_FIRST
                                               : ch_r + pnlt_pkg::plane_t'(1);
      end
    end
  end

  // per-channel result
  logic [pnlt_pkg::BYTE_W-1:0]  sample;
  logic [pnlt_pkg::VALUE_W-1:0] value;
  logic [AW-1:0]                plane_off, addr;

  always_comb begin
    case (ch_r)
      pnlt_pkg::PLANE_FIRST:  sample = swap_r ? b2_r : b0_r;
      pnlt_pkg::PLANE_MIDDLE: sample = b1_r;
      default:                sample = swap_r ? b0_r : b2_r;
    endcase
    case (ch_r)
      pnlt_pkg::PLANE_FIRST:  plane_off = '0;
      pnlt_pkg::PLANE_MIDDLE: plane_off = AW'(plane_size_r);
      default:                plane_off = AW'({plane_size_r, 1'b0});
    endcase
    if (planar_r) begin
      addr = AW'(pix_r) + plane_off;
    end else begin
      addr = AW'({pix_r, 1'b0}) + AW'(pix_r) + AW'(ch_r);
    end
  end

  pnlt_scale u_scale (
    .sample (sample),
    .gain   (gain_r),
    .bias   (bias_r),
    .value  (value)
  );

  // output register
  logic [pnlt_pkg::ADDR_W-1:0]  addr_r;
  logic [pnlt_pkg::VALUE_W-1:0] value_r;
  pnlt_pkg::plane_t             plane_r;
  logic                         pixel_done_r, image_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= px_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && px_valid_r) begin
      addr_r       <= addr[pnlt_pkg::ADDR_W-1:0];
      value_r      <= value;
      plane_r      <= ch_r;
      pixel_done_r <= (ch_r == pnlt_pkg::PLANE_LAST);
      image_done_r <= (ch_r == pnlt_pkg::PLANE_LAST) && img_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_address = addr_r;
  assign out_scaled_value = value_r;
  assign out_plane_index  = plane_r;
  assign out_pixel_done   = pixel_done_r;
  assign out_image_done   = image_done_r;

  `PNLT_ASSERT_NEXT(a_take_starts_first, clk, rst_n, in_take, px_valid_r && (ch_r == pnlt_pkg::PLANE_FIRST), "pixel not loaded at first channel")
  `PNLT_ASSERT_IMPLY(a_image_done_on_pixel_done, clk, rst_n, out_valid_r && image_done_r, pixel_done_r, "image end without pixel end")
  `PNLT_ASSERT_IMPLY(a_done_on_last_plane, clk, rst_n, out_valid_r, pixel_done_r == (plane_r == pnlt_pkg::PLANE_LAST), "pixel end flag off its channel")
  `PNLT_ASSERT_NEXT(a_pixel_held_mid, clk, rst_n, out_valid_r && !out_stall && (plane_r != pnlt_pkg::PLANE_LAST), px_valid_r || out_valid_r, "pixel dropped before its last channel")

endmodule

>>> rtl/core/pnlt_scale.sv
`timescale 1ns / 1ps

module pnlt_scale (
  input  logic [pnlt_pkg::BYTE_W-1:0]  sample,
  input  logic [pnlt_pkg::COEF_W-1:0]  gain,
  input  logic [pnlt_pkg::COEF_W-1:0]  bias,
  output logic [pnlt_pkg::VALUE_W-1:0] value
);

  logic signed [32:0] prod;
  logic signed [33:0] sum;

  assign prod = $signed({25'd0, sample}) * $signed({{9{gain[23]}}, gain});
  assign sum  = $signed({prod[32], prod}) + $signed({{10{bias[23]}}, bias});

  // saturate to signed 32 bits
  always_comb begin
    if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111)) begin
      value = sum[31:0];
    end else if (sum[33]) begin
      value = pnlt_pkg::VALUE_MIN;
    end else begin
      value = pnlt_pkg::VALUE_MAX;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import pnlt_pkg::*;

  localparam int ITEM_TARGET = 420;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 4000;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    logic [DIM_CFG_W-1:0] height, width;
    logic                 planar, swap;
    logic [COEF_W-1:0]    gain, bias;
  } setup_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] value;
    plane_t             plane;
    logic               pixel_end;
    logic               image_end;
  } element_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [BYTE_W-1:0]      in_byte_zero = '0;
  logic [BYTE_W-1:0]      in_byte_one = '0;
  logic [BYTE_W-1:0]      in_byte_two = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ADDR_W-1:0]      out_dest_address;
  logic [VALUE_W-1:0]     out_scaled_value;
  logic [PLANE_W-1:0]     out_plane_index;
  logic                   out_pixel_done;
  logic                   out_image_done;

  setup_t      active_setup;
  int unsigned row_pos, col_pos;
  element_t    pending_elems[$];
  element_t    head;

  int pixels_sent, beats_checked, images_seen, setups_applied, mismatches;
  int hold_req, hold_seen, hold_left, stall_left, stall_roll, idle_cycles;
  logic rx_steady = 1'b0;
  bit   tx_steady;

  pixel_normalize_layout_transpose_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_zero     (in_byte_zero),
    .in_byte_one      (in_byte_one),
    .in_byte_two      (in_byte_two),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dest_address (out_dest_address),
    .out_scaled_value (out_scaled_value),
    .out_plane_index  (out_plane_index),
    .out_pixel_done   (out_pixel_done),
    .out_image_done   (out_image_done)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_dim(logic [DIM_CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return '1;
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2, 3, 4: return COEF_W'($urandom_range(0, 1 << 19)) - COEF_W'(1 << 18);
      5: return GAIN_RST;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic setup_t random_setup();
    setup_t s;
    int r;
    r = $urandom_range(0, 99);
    s.height = (r < 85) ? DIM_CFG_W'($urandom_range(1, 5)) :
               (r < 95) ? DIM_CFG_W'($urandom_range(6, 20)) : DIM_CFG_W'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    s.width = (r < 85) ? DIM_CFG_W'($urandom_range(1, 6)) :
              (r < 95) ? DIM_CFG_W'($urandom_range(7, 24)) : '0;
    s.planar = 1'($urandom);
    s.swap = 1'($urandom);
    s.gain = rand_coef();
    s.bias = rand_coef();
    return s;
  endfunction

  // expected elements of one pixel, then step the raster position
  task automatic normalize_pixel(input logic [BYTE_W-1:0] b0, b1, b2);
    int unsigned h, w;
    logic [BYTE_W-1:0] src[CHANNELS];
    longint pix, addr, v;
    bit last_col, last_row;
    element_t e;
    h = clamp_dim(active_setup.height);
    w = clamp_dim(active_setup.width);
    last_col = (col_pos + 1) >= w;
    last_row = (row_pos + 1) >= h;
    pix = longint'(row_pos) * w + col_pos;
    src[0] = b0;
    src[1] = b1;
    src[2] = b2;
    for (int c = 0; c < CHANNELS; c++) begin
      addr = active_setup.planar ? longint'(c) * h * w + pix : pix * CHANNELS + c;
      v = longint'(src[active_setup.swap ? CHANNELS - 1 - c : c])
          * longint'($signed(active_setup.gain)) + longint'($signed(active_setup.bias));
      if (v > longint'(VALUE_MAX)) v = longint'(VALUE_MAX);
      else if (v < longint'($signed(VALUE_MIN))) v = longint'($signed(VALUE_MIN));
      e.addr = addr[ADDR_W-1:0];
      e.value = v[VALUE_W-1:0];
      e.plane = plane_t'(c);
      e.pixel_end = (e.plane == PLANE_LAST);
      e.image_end = e.pixel_end && last_col && last_row;
      pending_elems.push_back(e);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  task automatic send_pixel(input logic [BYTE_W-1:0] b0, b1, b2);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_zero <= b0;
    in_byte_one <= b1;
    in_byte_two <= b2;
    do @(posedge clk); while (in_stall !== 1'b0);
    normalize_pixel(b0, b1, b2);
    pixels_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_setup(input setup_t s);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(s.height);
    @(posedge clk);
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(s.width);
    @(posedge clk);
    cfg_index <= CFG_PLANAR_LAYOUT;
    cfg_wdata <= CFG_DATA_W'(s.planar);
    @(posedge clk);
    cfg_index <= CFG_SWAP_RED_BLUE;
    cfg_wdata <= CFG_DATA_W'(s.swap);
    @(posedge clk);
    cfg_index <= CFG_GAIN;
    cfg_wdata <= s.gain;
    @(posedge clk);
    cfg_index <= CFG_BIAS;
    cfg_wdata <= s.bias;
    @(posedge clk);
    // unmapped indexes must leave everything alone
    cfg_index <= CFG_SPARE_LO;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_index <= CFG_SPARE_HI;
    cfg_wdata <= 24'h000001;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_setup = s;
    setups_applied++;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got, want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch %s after %0d beats: got %h want %h",
               $time, what, beats_checked, got, want);
  endtask

  task automatic test_reset_defaults();
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel(8'h5a, 8'ha5, 8'h3c);
  endtask

  task automatic test_dimension_limits();
    apply_setup('{11'd0, 11'd2047, 1'b0, 1'b1, 24'h7fffff, 24'h7fffff});
    send_pixel(8'hff, 8'h00, 8'h80);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'h01, 8'h02, 8'h03);
    apply_setup('{11'd2047, 11'd0, 1'b1, 1'b0, 24'h800000, 24'h800000});
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h80, 8'h40, 8'h20);
  endtask

  task automatic test_full_image_wrap();
    apply_setup('{11'd2, 11'd3, 1'b1, 1'b0, 24'h018000, 24'hff0000});
    send_random(9);
  endtask

  task automatic test_reconfig_mid_image();
    apply_setup('{11'd8, 11'd8, 1'b0, 1'b0, GAIN_RST, BIAS_RST});
    send_random(5);
    apply_setup('{11'd8, 11'd3, 1'b0, 1'b0, GAIN_RST, BIAS_RST});
    send_random(1);
    apply_setup('{11'd1, 11'd1, 1'b1, 1'b1, GAIN_RST, 24'h000100});
    send_random(1);
  endtask

  task automatic test_backpressure_hold();
    apply_setup(random_setup());
    hold_req <= hold_req + 1;
    tx_steady = 1'b1;
    send_random(30);
    tx_steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    send_random(12);
    wait_drained();
    send_random(12);
  endtask

  task automatic test_random_images();
    setup_t s;
    int len, phase;
    phase = 0;
    while (pixels_sent < ITEM_TARGET) begin
      s = random_setup();
      apply_setup(s);
      len = clamp_dim(s.height) * clamp_dim(s.width) * $urandom_range(1, 3)
            + $urandom_range(0, 2);
      if (len > 60) len = 60;
      if (len > ITEM_TARGET - pixels_sent) len = ITEM_TARGET - pixels_sent;
      if (phase % 3 == 2) begin
        rx_steady <= 1'b1;
        tx_steady = 1'b1;
      end
      send_random(len);
      rx_steady <= 1'b0;
      tx_steady = 1'b0;
      phase++;
    end
  endtask

  // result side: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_steady) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 72) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_elems.size() == 0) begin
        flag_mismatch("unexpected beat", 32'(out_dest_address), '0);
      end else begin
        head = pending_elems.pop_front();
        if (out_dest_address !== head.addr)
          flag_mismatch("dest_address", 32'(out_dest_address), 32'(head.addr));
        if (out_scaled_value !== head.value)
          flag_mismatch("scaled_value", out_scaled_value, head.value);
        if (out_plane_index !== head.plane)
          flag_mismatch("plane_index", 32'(out_plane_index), 32'(head.plane));
        if (out_pixel_done !== head.pixel_end)
          flag_mismatch("pixel_done", 32'(out_pixel_done), 32'(head.pixel_end));
        if (out_image_done !== head.image_end)
          flag_mismatch("image_done", 32'(out_image_done), 32'(head.image_end));
        beats_checked++;
        if (head.image_end) images_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d elements outstanding",
                 idle_cycles, pending_elems.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    active_setup = '{HEIGHT_RST, WIDTH_RST, PLANAR_RST, SWAP_RST, GAIN_RST, BIAS_RST};
    row_pos = 0;
    col_pos = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_dimension_limits();
    test_full_image_wrap();
    test_reconfig_mid_image();
    test_backpressure_hold();
    test_sender_pause();
    test_random_images();
    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_elems.size() != 0)
      flag_mismatch("elements never returned", 32'(pending_elems.size()), '0);
    $display("pixels sent %0d, elements checked %0d, images completed %0d",
             pixels_sent, beats_checked, images_seen);
    $display("register setups %0d incl. clamped sizes, mid-image changes, long hold-off",
             setups_applied);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pnlt_pkg.sv
rtl/core/pnlt_scale.sv
rtl/core/pixel_normalize_layout_transpose_core.sv
tb/tb_top.sv
